### rtl/assert_macros.svh
// Assertion macros used by cafc_core.
// Expects signals clk and arst_n in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, disabled while in reset.
`define ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

### rtl/cafc_pkg.sv
// Package for the credit/ack flow control block: beat types, config struct,
// register indexes and default parameters. No dependencies.
package cafc_pkg;

	localparam int NUM_VC_DEF         = 4;
	localparam int ACK_FIELD_BITS_DEF = 8;

	localparam int CNT_W   = 7;
	localparam int OUT_MAX = 127;
	localparam int CFG_W   = 7;
	localparam int IDX_W   = 2;

	localparam logic [IDX_W-1:0] REG_BUFFER_CAPACITY = 2'd0;
	localparam logic [IDX_W-1:0] REG_PACKET_SIZE     = 2'd1;
	localparam logic [IDX_W-1:0] REG_ACK_ENABLED     = 2'd2;

	localparam logic [CNT_W-1:0] CAPACITY_RST = 7'd16;
	localparam logic [CNT_W-1:0] PKT_SIZE_RST = 7'd9;

	typedef struct packed {
		logic        send_valid;
		logic [1:0]  send_vc;
		logic        owe_valid;
		logic [1:0]  owe_vc;
		logic        rx_ack_valid;
		logic        rx_ack_upper_half;
		logic [15:0] rx_ack_counts;
	} in_item_t;

	typedef struct packed {
		logic        ack_out_valid;
		logic        ack_out_upper_half;
		logic [15:0] ack_out_counts;
		logic [3:0]  ready_mask;
	} out_item_t;

	typedef struct packed {
		logic [CNT_W-1:0] buffer_capacity;
		logic [CNT_W-1:0] packet_size;
		logic             ack_enabled;
	} cfg_t;

endpackage

### rtl/credit_ack_flow_control.sv
// Top level of the credit/ack flow control block: input and result registers.
// Depends on cafc_pkg, cafc_cfg_regs and cafc_core.
//
// Usage:
//   Input channel in_valid/in_stall/in_data carries one beat per router cycle while in_stall is low:
//   the sent flit, the owed ack and any received ack flit. Output channel
//   out_valid/out_stall/out_data returns one beat per input beat: the ack
//   flit to send (if any) and the per-VC ready mask after the update.
//   Config: cfg_we/cfg_index/cfg_data write buffer_capacity (0),
//   packet_size (1) and ack_enabled (2); write only while the block is idle.
// Path: an accepted beat is registered in the input stage; its result is
//   registered when the result stage advances and shows on out_data from then on.
// Throughput: one beat per cycle while out_stall is low; the per-VC state
//   update is a single pass of logic between the input stage and the result register.
// Reset: counts and owed acks clear, ready flags set, half select to the
//   lower half, registers to 16 / 9 / 1; no beats are held.
// Stall: a stalled result holds; the input stage keeps one more beat, and
//   in_stall rises only when both stages are full.
module credit_ack_flow_control #(
	parameter int NUM_VC         = cafc_pkg::NUM_VC_DEF,
	parameter int ACK_FIELD_BITS = cafc_pkg::ACK_FIELD_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  cafc_pkg::in_item_t         in_data,
	output logic                       out_valid,
	input  logic                       out_stall,
	output cafc_pkg::out_item_t        out_data,
	input  logic                       cfg_we,
	input  logic [cafc_pkg::IDX_W-1:0] cfg_index,
	input  logic [cafc_pkg::CFG_W-1:0] cfg_data
);
	import cafc_pkg::*;

	cfg_t      cfg;
	in_item_t  item_s1;
	logic      valid_s1;
	out_item_t res_s2;
	logic      valid_s2;
	out_item_t res_n;
	logic      adv;
	logic      commit;

	assign adv      = !valid_s2 || !out_stall;
	assign commit   = adv && valid_s1;
	assign in_stall = valid_s1 && !adv;

	cafc_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.cfg      (cfg)
	);

	cafc_core #(
		.NUM_VC        (NUM_VC),
		.ACK_FIELD_BITS(ACK_FIELD_BITS)
	) u_core (
		.clk   (clk),
		.arst_n(arst_n),
		.cfg   (cfg),
		.item  (item_s1),
		.commit(commit),
		.result(res_n)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_valid && !in_stall)
				valid_s1 <= 1'b1;
			else if (adv)
				valid_s1 <= 1'b0;
			if (adv)
				valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall)
			item_s1 <= in_data;
		if (commit)
			res_s2 <= res_n;
	end

	assign out_valid = valid_s2;
	assign out_data  = res_s2;

endmodule

### rtl/cafc_cfg_regs.sv
// Configuration registers of the credit/ack flow control block.
// Depends on cafc_pkg.
module cafc_cfg_regs (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [cafc_pkg::IDX_W-1:0] cfg_index,
	input  logic [cafc_pkg::CFG_W-1:0] cfg_data,
	output cafc_pkg::cfg_t            cfg
);
	import cafc_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.buffer_capacity <= CAPACITY_RST;
			cfg_q.packet_size     <= PKT_SIZE_RST;
			cfg_q.ack_enabled     <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_BUFFER_CAPACITY: cfg_q.buffer_capacity <= cfg_data;
				REG_PACKET_SIZE:     cfg_q.packet_size     <= cfg_data;
				REG_ACK_ENABLED:     cfg_q.ack_enabled     <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### rtl/cafc_core.sv
// Per-VC credit state and next-state logic; produces one result per beat.
// Depends on cafc_pkg and assert_macros.svh.
module cafc_core #(
	parameter int NUM_VC         = cafc_pkg::NUM_VC_DEF,
	parameter int ACK_FIELD_BITS = cafc_pkg::ACK_FIELD_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cafc_pkg::cfg_t       cfg,
	input  cafc_pkg::in_item_t   item,
	input  logic                 commit,
	output cafc_pkg::out_item_t  result
);
	import cafc_pkg::*;
	`include "assert_macros.svh"

	localparam int HALF_LO = NUM_VC / 2;
	localparam int MASK_N  = (NUM_VC < 4) ? NUM_VC : 4;
	localparam logic [15:0] FIELD_MAX = 16'((32'd1 << ACK_FIELD_BITS) - 32'd1);

	logic [CNT_W-1:0]          outst_q [NUM_VC];
	logic [ACK_FIELD_BITS-1:0] owed_q  [NUM_VC];
	logic [NUM_VC-1:0]         ready_q;
	logic                      half_q;

	logic [CNT_W-1:0]          outst_n [NUM_VC];
	logic [ACK_FIELD_BITS-1:0] owed_n  [NUM_VC];
	logic [NUM_VC-1:0]         ready_n;
	logic                      half_n;

	logic        send_ack;
	logic        any_owed;
	logic [15:0] lo_pack;
	logic [15:0] hi_pack;
	logic [15:0] dec     [HALF_LO];

	always_comb begin
		logic [31:0]      acc_lo;
		logic [31:0]      acc_hi;
		logic             in_half;
		logic [15:0]      d;
		logic [CNT_W-1:0] o;
		logic             changed;

		send_ack = !item.send_valid && cfg.ack_enabled;
		changed  = (item.send_valid && cfg.ack_enabled) || item.rx_ack_valid;
		half_n   = send_ack ? !half_q : half_q;

		acc_lo   = '0;
		acc_hi   = '0;
		any_owed = 1'b0;
		for (int v = 0; v < NUM_VC; v++) begin
			in_half = half_q ? (v >= HALF_LO) : (v < HALF_LO);
			if (in_half && owed_q[v] != '0)
				any_owed = 1'b1;
			if (v < HALF_LO) begin
				if (v * ACK_FIELD_BITS < 16)
					acc_lo = acc_lo | (32'(owed_q[v]) << (v * ACK_FIELD_BITS));
			end else begin
				if ((v - HALF_LO) * ACK_FIELD_BITS < 16)
					acc_hi = acc_hi | (32'(owed_q[v]) << ((v - HALF_LO) * ACK_FIELD_BITS));
			end
		end
		lo_pack = acc_lo[15:0];
		hi_pack = acc_hi[15:0];

		for (int i = 0; i < HALF_LO; i++) begin
			if (i * ACK_FIELD_BITS < 16)
				dec[i] = (item.rx_ack_counts >> (i * ACK_FIELD_BITS)) & FIELD_MAX;
			else
				dec[i] = '0;
		end

		for (int v = 0; v < NUM_VC; v++) begin
			in_half = half_q ? (v >= HALF_LO) : (v < HALF_LO);

			owed_n[v] = (send_ack && in_half) ? '0 : owed_q[v];
			if (item.owe_valid && int'(item.owe_vc) == v && owed_n[v] != '1)
				owed_n[v] = owed_n[v] + 1'b1;

			o = outst_q[v];
			if (item.send_valid && cfg.ack_enabled && int'(item.send_vc) == v
				&& o != CNT_W'(OUT_MAX))
				o = o + 1'b1;

			d = '0;
			if (item.rx_ack_upper_half) begin
				if (v >= HALF_LO && v < 2 * HALF_LO)
					d = dec[v - HALF_LO];
			end else begin
				if (v < HALF_LO)
					d = dec[v];
			end
			if (item.rx_ack_valid) begin
				if (16'(o) > d)
					o = o - d[CNT_W-1:0];
				else
					o = '0;
			end
			outst_n[v] = o;

			if (changed && cfg.ack_enabled)
				ready_n[v] = {1'b0, cfg.buffer_capacity} >=
					({1'b0, o} + {1'b0, cfg.packet_size});
			else
				ready_n[v] = ready_q[v];
		end

		result = '0;
		if (send_ack && any_owed) begin
			result.ack_out_valid      = 1'b1;
			result.ack_out_upper_half = half_q;
			result.ack_out_counts     = half_q ? hi_pack : lo_pack;
		end
		for (int v = 0; v < MASK_N; v++)
			result.ready_mask[v] = !cfg.ack_enabled || ready_n[v];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int v = 0; v < NUM_VC; v++) begin
				outst_q[v] <= '0;
				owed_q[v]  <= '0;
			end
			ready_q <= '1;
			half_q  <= 1'b0;
		end else if (commit) begin
			for (int v = 0; v < NUM_VC; v++) begin
				outst_q[v] <= outst_n[v];
				owed_q[v]  <= owed_n[v];
			end
			ready_q <= ready_n;
			half_q  <= half_n;
		end
	end

	`ASSERT_NEXT(a_half_flips, commit && send_ack, half_q != $past(half_q))
	`ASSERT_NEXT(a_half_holds, commit && item.send_valid, half_q == $past(half_q))
	`ASSERT_NOW(a_ack_only_idle, result.ack_out_valid, !item.send_valid && cfg.ack_enabled)

endmodule

### bench/credit_ack_flow_control_tb.sv
// Self-checking bench for credit_ack_flow_control: per-VC credit counts, ack flit
// generation and ready mask, checked beat by beat against a local model.
// Depends on cafc_pkg and the RTL top level only.
`timescale 1ns / 1ps

module credit_ack_flow_control_tb;
	import cafc_pkg::*;

	localparam int NVC         = NUM_VC_DEF;
	localparam int HALF        = NVC / 2;
	localparam int FW          = ACK_FIELD_BITS_DEF;
	localparam int FMAX        = (1 << FW) - 1;
	localparam int IN_W        = $bits(in_item_t);
	localparam int CYCLE_LIMIT = 200000;
	localparam int PHASES      = 7;
	localparam int PHASE_BEATS = 240;
	localparam int BURST_BEATS = 300;

	localparam int PH_CAP [PHASES] = '{64, 1, 1, 64, 20, 64, 0};
	localparam int PH_PKT [PHASES] = '{1, 64, 1, 64, 4, 9, 0};
	localparam int PH_EN  [PHASES] = '{1, 1, 1, 0, 1, 0, 1};

	typedef struct {
		in_item_t  beat;
		bit        typed;
		out_item_t want;
	} dir_row_t;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	in_item_t            in_data;
	logic                out_valid;
	logic                out_stall;
	out_item_t           out_data;
	logic                cfg_we;
	logic [IDX_W-1:0]    cfg_index;
	logic [CFG_W-1:0]    cfg_data;

	// model state
	logic [CNT_W-1:0] vc_outstanding [NVC];
	logic [FW-1:0]    vc_owed [NVC];
	logic             vc_ready [NVC];
	logic             upper_turn;
	logic [CNT_W-1:0] cfg_capacity;
	logic [CNT_W-1:0] cfg_packet;
	logic             cfg_ack_on;

	out_item_t port_updates_due [$];
	dir_row_t  dir_tab [$];
	int        errors = 0;
	int        cycles = 0;
	int        idle_pct;
	int        stall_pct;
	int        hold_left;
	int        hold_reqs = 0;

	credit_ack_flow_control uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("TEST FAILED");
			$finish;
		end
	end

	function automatic out_item_t predict_port_update(input in_item_t b);
		out_item_t   res;
		bit          touched;
		bit          any;
		int          first;
		int          dec;
		logic [31:0] acc;
		res = '0;
		touched = 1'b0;
		if (b.send_valid) begin
			if (cfg_ack_on) begin
				if (vc_outstanding[b.send_vc] < OUT_MAX)
					vc_outstanding[b.send_vc] = vc_outstanding[b.send_vc] + 1'b1;
				touched = 1'b1;
			end
		end else if (cfg_ack_on) begin
			first = upper_turn ? HALF : 0;
			any = 1'b0;
			for (int i = 0; i < HALF; i++)
				if (vc_owed[first + i] != 0)
					any = 1'b1;
			if (any) begin
				acc = '0;
				for (int i = 0; i < HALF; i++) begin
					if (i * FW < 16)
						acc = acc | (32'(vc_owed[first + i]) << (i * FW));
					vc_owed[first + i] = '0;
				end
				res.ack_out_valid = 1'b1;
				res.ack_out_upper_half = upper_turn;
				res.ack_out_counts = acc[15:0];
			end
			upper_turn = ~upper_turn;
		end
		if (b.rx_ack_valid) begin
			first = b.rx_ack_upper_half ? HALF : 0;
			for (int i = 0; i < HALF; i++) begin
				dec = (i * FW < 16) ? int'((32'(b.rx_ack_counts) >> (i * FW)) & FMAX) : 0;
				if (int'(vc_outstanding[first + i]) > dec)
					vc_outstanding[first + i] = CNT_W'(int'(vc_outstanding[first + i]) - dec);
				else
					vc_outstanding[first + i] = '0;
			end
			touched = 1'b1;
		end
		if (touched && cfg_ack_on)
			for (int v = 0; v < NVC; v++)
				vc_ready[v] = int'(cfg_capacity) >= int'(vc_outstanding[v]) + int'(cfg_packet);
		if (b.owe_valid && vc_owed[b.owe_vc] < FMAX)
			vc_owed[b.owe_vc] = vc_owed[b.owe_vc] + 1'b1;
		for (int v = 0; v < NVC && v < 4; v++)
			res.ready_mask[v] = !cfg_ack_on || vc_ready[v];
		return res;
	endfunction

	function automatic in_item_t mk_beat(bit sv, int svc, bit ov, int ovc, bit rv, bit ru,
			int rc);
		in_item_t b;
		b.send_valid = sv;
		b.send_vc = svc[1:0];
		b.owe_valid = ov;
		b.owe_vc = ovc[1:0];
		b.rx_ack_valid = rv;
		b.rx_ack_upper_half = ru;
		b.rx_ack_counts = rc[15:0];
		return b;
	endfunction

	// downstream acks never exceed what is outstanding
	function automatic in_item_t flow_beat();
		in_item_t b;
		int       base;
		b.send_valid = ($urandom_range(99) < 65);
		b.send_vc = 2'($urandom_range(3));
		b.owe_valid = ($urandom_range(99) < 40);
		b.owe_vc = 2'($urandom_range(3));
		b.rx_ack_valid = ($urandom_range(99) < 25);
		b.rx_ack_upper_half = 1'($urandom_range(1));
		base = b.rx_ack_upper_half ? HALF : 0;
		b.rx_ack_counts = '0;
		for (int i = 0; i < HALF; i++)
			b.rx_ack_counts[i*FW +: FW] =
				FW'($urandom_range(0, int'(vc_outstanding[base + i])));
		return b;
	endfunction

	task automatic flag_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch %s: got %0h want %0h at cycle %0d", what, got, want, cycles);
		errors++;
	endtask

	task automatic push_beat(input in_item_t b, input bit typed = 1'b0,
			input out_item_t want = '0);
		out_item_t modeled;
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= b;
		do @(posedge clk); while (in_stall);
		modeled = predict_port_update(b);
		port_updates_due.push_back(typed ? want : modeled);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (port_updates_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic load_settings(input int cap, input int pkt, input int en);
		cfg_we <= 1'b1;
		cfg_index <= REG_BUFFER_CAPACITY;
		cfg_data <= CFG_W'(cap);
		@(posedge clk);
		cfg_capacity = CNT_W'(cap);
		cfg_index <= REG_PACKET_SIZE;
		cfg_data <= CFG_W'(pkt);
		@(posedge clk);
		cfg_packet = CNT_W'(pkt);
		cfg_index <= REG_ACK_ENABLED;
		cfg_data <= CFG_W'(en);
		@(posedge clk);
		cfg_ack_on = en[0];
		cfg_we <= 1'b0;
	endtask

	// result side: check, then decide the stall for the next edge
	initial begin
		out_item_t want;
		int        holds_taken;
		out_stall = 1'b0;
		hold_left = 0;
		holds_taken = 0;
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall) begin
				if (port_updates_due.size() == 0) begin
					flag_mismatch("unexpected result beat", 32'(out_data), '0);
				end else begin
					want = port_updates_due.pop_front();
					if (out_data.ack_out_valid !== want.ack_out_valid)
						flag_mismatch("ack_out_valid", 32'(out_data.ack_out_valid),
							32'(want.ack_out_valid));
					if (out_data.ack_out_upper_half !== want.ack_out_upper_half)
						flag_mismatch("ack_out_upper_half", 32'(out_data.ack_out_upper_half),
							32'(want.ack_out_upper_half));
					if (out_data.ack_out_counts !== want.ack_out_counts)
						flag_mismatch("ack_out_counts", 32'(out_data.ack_out_counts),
							32'(want.ack_out_counts));
					if (out_data.ready_mask !== want.ready_mask)
						flag_mismatch("ready_mask", 32'(out_data.ready_mask),
							32'(want.ready_mask));
				end
			end
			if (holds_taken != hold_reqs) begin
				hold_left = 90;
				holds_taken = hold_reqs;
			end
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				out_stall <= ($urandom_range(99) < stall_pct);
			end
		end
	end

	initial begin
		int bvc;
		int ovc;
		idle_pct = 33;
		stall_pct = 33;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		cfg_capacity = CAPACITY_RST;
		cfg_packet = PKT_SIZE_RST;
		cfg_ack_on = 1'b1;
		upper_turn = 1'b0;
		for (int v = 0; v < NVC; v++) begin
			vc_outstanding[v] = '0;
			vc_owed[v] = '0;
			vc_ready[v] = 1'b1;
		end

		// directed rows, reset settings 16 / 9 / ack on
		dir_tab.push_back('{mk_beat(0, 0, 0, 0, 0, 0, 0), 1'b1,
			out_item_t'{1'b0, 1'b0, 16'h0000, 4'hF}});
		dir_tab.push_back('{mk_beat(1, 0, 0, 0, 0, 0, 0), 1'b1,
			out_item_t'{1'b0, 1'b0, 16'h0000, 4'hF}});
		dir_tab.push_back('{mk_beat(1, 0, 1, 1, 0, 0, 0), 1'b0, '0});
		dir_tab.push_back('{mk_beat(0, 0, 0, 0, 0, 0, 0), 1'b1,
			out_item_t'{1'b0, 1'b0, 16'h0000, 4'hF}});
		dir_tab.push_back('{mk_beat(0, 0, 0, 0, 0, 0, 0), 1'b1,
			out_item_t'{1'b1, 1'b0, 16'h0100, 4'hF}});
		dir_tab.push_back('{mk_beat(1, 2, 1, 2, 0, 0, 0), 1'b0, '0});
		dir_tab.push_back('{mk_beat(1, 3, 1, 3, 0, 0, 0), 1'b0, '0});
		dir_tab.push_back('{mk_beat(0, 0, 0, 0, 0, 0, 0), 1'b1,
			out_item_t'{1'b1, 1'b1, 16'h0101, 4'hF}});
		for (int k = 0; k < 7; k++)
			dir_tab.push_back('{mk_beat(1, 1, 0, 0, 0, 0, 0), 1'b0, '0});
		// eighth flit on VC 1 leaves less than a packet of room
		dir_tab.push_back('{mk_beat(1, 1, 0, 0, 0, 0, 0), 1'b1,
			out_item_t'{1'b0, 1'b0, 16'h0000, 4'hD}});
		dir_tab.push_back('{mk_beat(0, 0, 0, 0, 1, 0, 16'hFFFF), 1'b1,
			out_item_t'{1'b0, 1'b0, 16'h0000, 4'hF}});
		dir_tab.push_back('{mk_beat(1, 3, 1, 0, 1, 1, 16'hFFFF), 1'b0, '0});
		dir_tab.push_back('{mk_beat(1, 2, 0, 0, 1, 1, 16'h0100), 1'b0, '0});
		dir_tab.push_back('{mk_beat(0, 0, 1, 3, 1, 0, 16'h00FF), 1'b0, '0});
		dir_tab.push_back('{mk_beat(1, 3, 1, 3, 1, 1, 16'hFFFF), 1'b0, '0});
		dir_tab.push_back('{mk_beat(0, 0, 0, 0, 0, 0, 0), 1'b0, '0});
		dir_tab.push_back('{mk_beat(0, 0, 0, 0, 0, 0, 0), 1'b0, '0});

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[r])
			push_beat(dir_tab[r].beat, dir_tab[r].typed, dir_tab[r].want);
		drain();

		for (int ph = 0; ph < PHASES; ph++) begin
			if (ph == PHASES - 1)
				load_settings($urandom_range(1, 64), $urandom_range(1, 16), PH_EN[ph]);
			else
				load_settings(PH_CAP[ph], PH_PKT[ph], PH_EN[ph]);
			idle_pct = (ph == 3) ? 0 : 33;
			stall_pct = (ph == 3) ? 0 : 33;
			if (ph == 0) begin
				// burst of flits on one VC, owing acks on one VC: outstanding and owed counts both saturate
				bvc = $urandom_range(3);
				ovc = $urandom_range(3);
				for (int k = 0; k < BURST_BEATS; k++)
					push_beat(mk_beat(1, bvc, 1, ovc, 0, 0, 0));
			end
			for (int k = 0; k < PHASE_BEATS; k++) begin
				if (ph == 2 && k == PHASE_BEATS / 2)
					hold_reqs = hold_reqs + 1;
				if (ph == 4 && k == PHASE_BEATS / 2)
					drain();
				if ($urandom_range(99) < 75)
					push_beat(flow_beat());
				else
					push_beat(in_item_t'(IN_W'($urandom)));
			end
			drain();
		end

		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
